/* hdl/asrta_pkg.sv */
// shared types and constants for the averaged scale reading to ascii unit
`timescale 1ns / 1ps
package asrta_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int SUM_W      = 14;
   localparam int CNT_W      = 5;
   localparam int GAIN_W     = 16;
   localparam int OFFSET_W   = 10;
   localparam int VALUE_W    = 14;
   localparam int ASCII_W    = 6;
   localparam int PROD_W     = SUM_W + GAIN_W;
   localparam int Q12_SHIFT  = 12;
   localparam int QUO_W      = PROD_W - Q12_SHIFT;
   localparam int REM_W      = 4;
   localparam int TRIAL_W    = REM_W + 1;
   localparam int DIGITS     = 4;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_SAMPLES   = 16;
   localparam int READING_MAX   = 9999;
   localparam int ASCII_ZERO    = 48;
   localparam int SAMPLES_RESET = 10;
   localparam int GAIN_RESET    = 27156;
   localparam int OFFSET_RESET  = 84;

   localparam int DIV_STEPS = QUO_W;
   localparam int BCD_STEPS = VALUE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES = 2'd0,
      CSR_GAIN    = 2'd1,
      CSR_OFFSET  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCALE,
      ST_BCD,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic take;
      logic div_step;
      logic scale;
      logic bcd_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic fire;
      logic out_busy;
   } status_type;

endpackage

/* hdl/averaged_scale_reading_to_ascii_unit.sv */
// top level of the averaged scale reading to ascii unit
`timescale 1ns / 1ps
// Each accepted item is one timer tick with a 10-bit sample. A tick that only adds
// its sample to the running sum yields no result. The tick that finds the configured
// number of samples collected drops its sample and starts a reading. The product of
// the sum and the gain, shifted right by 12 bits, is captured as that tick is
// accepted. Then come a one-bit-per-cycle restoring divider for the divide by the
// sample count, a step to subtract the offset and clamp to 0..9999, shift-add-3
// binary to bcd conversion and the load of the result register. A new tick can be
// taken the cycle after that load. Input is stalled for the whole reading. A result
// still waiting on rsp_stall holds off only the load of the next reading and the
// input behind it, not plain ticks.
// Configuration writes are always taken (csr_ready is tied high) and must only be
// issued while no reading is under way.
module averaged_scale_reading_to_ascii_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [asrta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asrta_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [asrta_pkg::SAMPLE_W-1:0]       req_adc_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [asrta_pkg::VALUE_W-1:0]        rsp_weight_value,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_thousands,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_hundreds,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_tens,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_units,
   output logic                                 rsp_clamped
);
   import asrta_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   asrta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   asrta_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_adc_sample      (req_adc_sample),
      .cmd                 (cmd),
      .status              (status),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_weight_value    (rsp_weight_value),
      .rsp_ascii_thousands (rsp_ascii_thousands),
      .rsp_ascii_hundreds  (rsp_ascii_hundreds),
      .rsp_ascii_tens      (rsp_ascii_tens),
      .rsp_ascii_units     (rsp_ascii_units),
      .rsp_clamped         (rsp_clamped)
   );

endmodule

/* hdl/asrta_ctrl.sv */
// controller state machine sequencing accumulate, divide, clamp and digit conversion
`timescale 1ns / 1ps
module asrta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  asrta_pkg::status_type status,
   output asrta_pkg::cmd_type    cmd
);
   import asrta_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.fire) begin
                  state_in = ST_DIV;
                  cnt_in   = '0;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = '0;
            state_in  = ST_BCD;
         end
         ST_BCD: begin
            cmd.bcd_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(BCD_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/asrta_dp.sv */
// datapath: registers, accumulator, multiplier, serial divider, clamp, double dabble, output
`timescale 1ns / 1ps
module asrta_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [asrta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asrta_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [asrta_pkg::SAMPLE_W-1:0]       req_adc_sample,
   input  asrta_pkg::cmd_type                   cmd,
   output asrta_pkg::status_type                status,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [asrta_pkg::VALUE_W-1:0]        rsp_weight_value,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_thousands,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_hundreds,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_tens,
   output logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_units,
   output logic                                 rsp_clamped
);
   import asrta_pkg::*;

   logic [CNT_W-1:0]    samples_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                rsp_valid_ff;

   logic [CNT_W-1:0]    divisor_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [VALUE_W-1:0]  bin_ff;
   logic [BCD_W-1:0]    bcd_ff;
   logic                clip_ff;

   logic [VALUE_W-1:0]  out_value_ff;
   logic [ASCII_W-1:0]  out_thou_ff, out_hund_ff, out_tens_ff, out_units_ff;
   logic                out_clip_ff;

   logic [CNT_W-1:0]    eff_samples;
   logic [PROD_W-1:0]   product;
   logic [TRIAL_W-1:0]  trial;
   logic                trial_ge;
   logic [QUO_W-1:0]    diff;
   logic [VALUE_W-1:0]  val_in;
   logic                clip_in;
   logic [BCD_W-1:0]    bcd_adj;

   // effective sample count, zero as one and above sixteen as sixteen
   always_comb begin
      if (samples_ff == '0) begin
         eff_samples = CNT_W'(1);
      end else if (samples_ff > CNT_W'(MAX_SAMPLES)) begin
         eff_samples = CNT_W'(MAX_SAMPLES);
      end else begin
         eff_samples = samples_ff;
      end
   end

   assign status.fire     = (count_ff >= eff_samples);
   assign status.out_busy = rsp_valid_ff & rsp_stall;

   assign product  = PROD_W'(sum_ff) * PROD_W'(gain_ff);
   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge = (trial >= divisor_ff);
   assign diff     = quo_ff - QUO_W'(offset_ff);

   always_comb begin
      if (quo_ff < QUO_W'(offset_ff)) begin
         val_in  = '0;
         clip_in = 1'b1;
      end else if (diff > QUO_W'(READING_MAX)) begin
         val_in  = VALUE_W'(READING_MAX);
         clip_in = 1'b1;
      end else begin
         val_in  = diff[VALUE_W-1:0];
         clip_in = 1'b0;
      end
   end

   // add three to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff   <= CNT_W'(SAMPLES_RESET);
         gain_ff      <= GAIN_W'(GAIN_RESET);
         offset_ff    <= OFFSET_W'(OFFSET_RESET);
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SAMPLES: samples_ff <= csr_wdata[CNT_W-1:0];
               CSR_GAIN:    gain_ff    <= csr_wdata[GAIN_W-1:0];
               CSR_OFFSET:  offset_ff  <= csr_wdata[OFFSET_W-1:0];
               default: ;
            endcase
         end
         if (cmd.take) begin
            if (status.fire) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_ff + SUM_W'(req_adc_sample);
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && status.fire) begin
         quo_ff     <= product[PROD_W-1:Q12_SHIFT];
         divisor_ff <= count_ff;
         rem_ff     <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ge ? REM_W'(trial - divisor_ff) : REM_W'(trial);
         quo_ff <= {quo_ff[QUO_W-2:0], trial_ge};
      end
      if (cmd.scale) begin
         val_ff  <= val_in;
         bin_ff  <= val_in;
         clip_ff <= clip_in;
         bcd_ff  <= '0;
      end
      if (cmd.bcd_step) begin
         bcd_ff <= {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_ff <= {bin_ff[VALUE_W-2:0], 1'b0};
      end
      if (cmd.load_out) begin
         out_value_ff <= val_ff;
         out_thou_ff  <= ASCII_W'(ASCII_ZERO) + ASCII_W'(bcd_ff[15:12]);
         out_hund_ff  <= ASCII_W'(ASCII_ZERO) + ASCII_W'(bcd_ff[11:8]);
         out_tens_ff  <= ASCII_W'(ASCII_ZERO) + ASCII_W'(bcd_ff[7:4]);
         out_units_ff <= ASCII_W'(ASCII_ZERO) + ASCII_W'(bcd_ff[3:0]);
         out_clip_ff  <= clip_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_weight_value    = out_value_ff;
   assign rsp_ascii_thousands = out_thou_ff;
   assign rsp_ascii_hundreds  = out_hund_ff;
   assign rsp_ascii_tens      = out_tens_ff;
   assign rsp_ascii_units     = out_units_ff;
   assign rsp_clamped         = out_clip_ff;

endmodule

/* hdl/asrta_checker.sv */
// port-level checker for the averaged scale reading to ascii unit, with its bind
`timescale 1ns / 1ps
module asrta_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [asrta_pkg::VALUE_W-1:0]        rsp_weight_value,
   input logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_thousands,
   input logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_hundreds,
   input logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_tens,
   input logic [asrta_pkg::ASCII_W-1:0]        rsp_ascii_units,
   input logic                                 rsp_clamped
);
   import asrta_pkg::*;

   // no item out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_value)
         && $stable(rsp_ascii_units) && $stable(rsp_clamped))
      else $error("stalled result item changed");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight_value <= VALUE_W'(READING_MAX))
      else $error("reading above 9999");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ascii_thousands >= 6'd48 && rsp_ascii_thousands <= 6'd57
         && rsp_ascii_hundreds >= 6'd48 && rsp_ascii_hundreds <= 6'd57
         && rsp_ascii_tens >= 6'd48 && rsp_ascii_tens <= 6'd57
         && rsp_ascii_units >= 6'd48 && rsp_ascii_units <= 6'd57)
      else $error("ascii digit out of range");

   // a zero reading shows a zero units digit
   a_zero_reading_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_weight_value == '0 && rsp_ascii_units != 6'd48 |-> 1'b0)
      else $error("zero reading with nonzero units digit");

endmodule

bind averaged_scale_reading_to_ascii_unit asrta_checker u_asrta_checker (.*);

/* tb/averaged_scale_reading_to_ascii_unit_tb.sv */
// self-checking testbench for the averaged scale reading to ascii unit
`timescale 1ns / 1ps
module averaged_scale_reading_to_ascii_unit_tb;
   import asrta_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES  = 48;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [VALUE_W-1:0] weight;
      logic [ASCII_W-1:0] thousands;
      logic [ASCII_W-1:0] hundreds;
      logic [ASCII_W-1:0] tens;
      logic [ASCII_W-1:0] units;
      logic               clamped;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_adc_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [VALUE_W-1:0]    rsp_weight_value;
   logic [ASCII_W-1:0]    rsp_ascii_thousands;
   logic [ASCII_W-1:0]    rsp_ascii_hundreds;
   logic [ASCII_W-1:0]    rsp_ascii_tens;
   logic [ASCII_W-1:0]    rsp_ascii_units;
   logic                  rsp_clamped;

   // predictor state and configuration
   logic [CNT_W-1:0]    cfg_samples;
   logic [GAIN_W-1:0]   cfg_gain;
   logic [OFFSET_W-1:0] cfg_offset;
   logic [SUM_W-1:0]    sum_acc;
   logic [CNT_W-1:0]    ticks_seen;
   reading_type         readings_due[$];

   int  failures;
   int  idle_cycles;
   bit  idle_on;
   bit  stall_on;
   bit  long_hold;

   averaged_scale_reading_to_ascii_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_weight_value    (rsp_weight_value),
      .rsp_ascii_thousands (rsp_ascii_thousands),
      .rsp_ascii_hundreds  (rsp_ascii_hundreds),
      .rsp_ascii_tens      (rsp_ascii_tens),
      .rsp_ascii_units     (rsp_ascii_units),
      .rsp_clamped         (rsp_clamped)
   );

   always #4 clock = ~clock;

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%t mismatch: %s", $realtime, msg);
      end
   endtask

   function automatic void reset_model();
      cfg_samples = CNT_W'(SAMPLES_RESET);
      cfg_gain    = GAIN_W'(GAIN_RESET);
      cfg_offset  = OFFSET_W'(OFFSET_RESET);
      sum_acc     = '0;
      ticks_seen  = '0;
   endfunction

   // accumulate a tick, or turn the collected sum into a reading
   function automatic void scale_tick(input logic [SAMPLE_W-1:0] sample);
      int unsigned      n;
      longint unsigned  scaled;
      longint unsigned  value;
      reading_type      r;
      n = cfg_samples;
      if (n == 0) n = 1;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      if (ticks_seen < n) begin
         sum_acc    = sum_acc + SUM_W'(sample);
         ticks_seen = ticks_seen + 1'b1;
      end else begin
         scaled = (longint'(sum_acc) * longint'(cfg_gain))
                  / (longint'(ticks_seen) << Q12_SHIFT);
         r.clamped = 1'b0;
         if (scaled < cfg_offset) begin
            value     = 0;
            r.clamped = 1'b1;
         end else begin
            value = scaled - cfg_offset;
            if (value > READING_MAX) begin
               value     = READING_MAX;
               r.clamped = 1'b1;
            end
         end
         r.weight    = VALUE_W'(value);
         r.thousands = ASCII_W'(ASCII_ZERO + value / 1000);
         r.hundreds  = ASCII_W'(ASCII_ZERO + (value / 100) % 10);
         r.tens      = ASCII_W'(ASCII_ZERO + (value / 10) % 10);
         r.units     = ASCII_W'(ASCII_ZERO + value % 10);
         readings_due.push_back(r);
         sum_acc    = '0;
         ticks_seen = '0;
      end
   endfunction

   task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scale_tick(sample);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SAMPLES: cfg_samples = data[CNT_W-1:0];
         CSR_GAIN:    cfg_gain = data;
         CSR_OFFSET:  cfg_offset = data[OFFSET_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic random_config();
      logic [CSR_DATA_W-1:0] data;
      if ($urandom_range(0, 3) != 0) begin
         data = CSR_DATA_W'($urandom);
         case ($urandom_range(0, 6))
            0: data[CNT_W-1:0] = 5'd0;
            1: data[CNT_W-1:0] = 5'd1;
            2: data[CNT_W-1:0] = 5'd16;
            3: data[CNT_W-1:0] = 5'd17;
            4: data[CNT_W-1:0] = 5'd31;
            default: data[CNT_W-1:0] = CNT_W'($urandom_range(1, 16));
         endcase
         write_reg(CSR_SAMPLES, data);
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0: data = '0;
            1: data = '1;
            2, 3: data = CSR_DATA_W'($urandom_range(2000, 30000));
            default: data = CSR_DATA_W'($urandom);
         endcase
         write_reg(CSR_GAIN, data);
      end
      if ($urandom_range(0, 3) != 0) begin
         data = CSR_DATA_W'($urandom);
         case ($urandom_range(0, 3))
            0: data[OFFSET_W-1:0] = '0;
            1: data[OFFSET_W-1:0] = '1;
            2: data[OFFSET_W-1:0] = OFFSET_W'($urandom_range(0, 200));
            default: ;
         endcase
         write_reg(CSR_OFFSET, data);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   task automatic run_phases(input int phases, input int items);
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         random_config();
         for (int i = 0; i < items; i++) send_tick(pick_sample());
      end
   endtask

   task automatic test_reset_defaults();
      for (int i = 0; i < 10; i++) send_tick('1);
      send_tick('1);
   endtask

   task automatic test_extremes();
      wait_idle();
      write_reg(CSR_SAMPLES, 16'd1);
      write_reg(CSR_GAIN, 16'd0);
      send_tick('1);
      send_tick('0);
      wait_idle();
      write_reg(CSR_GAIN, 16'hFFFF);
      write_reg(CSR_OFFSET, 16'd0);
      send_tick('1);
      send_tick('1);
      wait_idle();
      write_reg(CSR_SAMPLES, 16'hFFE0);
      write_reg(CSR_GAIN, 16'd4096);
      write_reg(CSR_OFFSET, 16'hFFFF);
      write_reg(CSR_SPARE, 16'hFFFF);
      send_tick('0);
      send_tick('1);
   endtask

   task automatic test_count_lowered();
      wait_idle();
      write_reg(CSR_SAMPLES, 16'd4);
      write_reg(CSR_OFFSET, 16'd0);
      send_tick('1);
      send_tick(10'd512);
      send_tick(10'd3);
      wait_idle();
      write_reg(CSR_SAMPLES, 16'd2);
      send_tick(10'd700);
   endtask

   task automatic test_random_traffic();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      run_phases(8, 100);
   endtask

   task automatic test_backpressure();
      wait_idle();
      idle_on  = 1'b0;
      stall_on = 1'b0;
      write_reg(CSR_SAMPLES, 16'd2);
      write_reg(CSR_GAIN, 16'd20000);
      write_reg(CSR_OFFSET, 16'd50);
      long_hold = 1'b1;
      for (int i = 0; i < 100; i++) send_tick(pick_sample());
      while (long_hold) @(posedge clock);
   endtask

   task automatic test_streaming();
      idle_on  = 1'b0;
      stall_on = 1'b0;
      run_phases(3, 100);
   endtask

   initial begin
      reset          <= 1'b1;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_SAMPLES;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_adc_sample <= '0;
      failures  = 0;
      idle_on   = 1'b1;
      stall_on  = 1'b1;
      long_hold = 1'b0;
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extremes();
      test_count_lowered();
      test_random_traffic();
      test_backpressure();
      test_streaming();
      wait_idle();
      if (failures == 0) begin
         $display("averaged_scale_reading_to_ascii_unit_tb OK");
      end else begin
         $display("averaged_scale_reading_to_ascii_unit_tb NOT OK");
      end
      $finish;
   end

   // receiver: random stall bursts, and one long hold on request
   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : reading_check
      reading_type got;
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_weight_value, rsp_ascii_thousands, rsp_ascii_hundreds,
                 rsp_ascii_tens, rsp_ascii_units, rsp_clamped};
         if (readings_due.size() == 0) begin
            note_failure($sformatf("unexpected reading %0d", got.weight));
         end else begin
            want = readings_due.pop_front();
            if (got.weight !== want.weight || got.thousands !== want.thousands
                || got.hundreds !== want.hundreds || got.tens !== want.tens
                || got.units !== want.units || got.clamped !== want.clamped) begin
               note_failure($sformatf(
                  "exp %0d '%c%c%c%c' clamp %0d, got %0d '%c%c%c%c' clamp %0d",
                  want.weight, 8'(want.thousands), 8'(want.hundreds), 8'(want.tens),
                  8'(want.units), want.clamped, got.weight, 8'(got.thousands),
                  8'(got.hundreds), 8'(got.tens), 8'(got.units), got.clamped));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("averaged_scale_reading_to_ascii_unit_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* files.f */
hdl/asrta_pkg.sv
hdl/asrta_ctrl.sv
hdl/asrta_dp.sv
hdl/averaged_scale_reading_to_ascii_unit.sv
hdl/asrta_checker.sv
tb/averaged_scale_reading_to_ascii_unit_tb.sv
